// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the phase timer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset
`define FBPT_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// Check that an antecedent implies a consequent in the same cycle
`define FBPT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`else

`define FBPT_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define FBPT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/fbpt_pkg.sv =====
// Types and constants of the focus/break phase timer
`timescale 1ns / 1ps

package fbpt_pkg;

    // Field widths
    localparam int unsigned SEC_W   = 16;
    localparam int unsigned MS_W    = 26;
    localparam int unsigned US_W    = 36;
    localparam int unsigned STAMP_W = 64;
    localparam int unsigned CNT_W   = 3;

    // Focus phases per cycle before a long break
    localparam logic [CNT_W-1:0] FOCUS_PER_CYCLE = 3'd4;

    // Time scale constants
    localparam logic [US_W-1:0] US_PER_S  = 36'd1000000;
    localparam logic [US_W-1:0] US_PER_MS = 36'd1000;
    localparam logic [MS_W-1:0] MS_PER_S  = 26'd1000;
    localparam logic [MS_W-1:0] MAX_REMAIN_MS = 26'd65535000;

    // Reset lengths in seconds
    localparam logic [SEC_W-1:0] RST_FOCUS_S = 16'd1500;
    localparam logic [SEC_W-1:0] RST_SHORT_S = 16'd300;
    localparam logic [SEC_W-1:0] RST_LONG_S  = 16'd900;
    localparam logic [US_W-1:0]  RST_LEFT_US = 36'(RST_FOCUS_S) * US_PER_S;

    // Divide by 1000 as a shift by 3, then a reciprocal multiply by 1/125
    localparam int unsigned      DIV_Y_W      = US_W - 3;
    localparam int unsigned      RECIP_SHIFT  = 32;
    localparam int unsigned      RECIP_W      = 26;
    localparam int unsigned      PROD_W       = DIV_Y_W + RECIP_W;
    localparam int unsigned      Q0_W         = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] DIV125_RECIP = 26'((64'd1 << RECIP_SHIFT) / 64'd125);
    localparam logic [DIV_Y_W-1:0] DIVISOR_125  = 33'd125;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FOCUS = 2'd0,
        CFG_SHORT = 2'd1,
        CFG_LONG  = 2'd2
    } t_cfg_index;

    // Command kinds
    typedef enum logic [2:0] {
        KIND_TICK    = 3'd0,
        KIND_START   = 3'd1,
        KIND_PAUSE   = 3'd2,
        KIND_RESUME  = 3'd3,
        KIND_STOP    = 3'd4,
        KIND_ACK     = 3'd5,
        KIND_RESTORE = 3'd6
    } t_kind;

    // Run states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_PAUSE = 2'd2,
        ST_ALERT = 2'd3
    } t_run_state;

    // Phases
    typedef enum logic [1:0] {
        PH_FOCUS = 2'd0,
        PH_SHORT = 2'd1,
        PH_LONG  = 2'd2
    } t_phase;

    // Snapshot carried down the output pipeline
    typedef struct packed {
        t_run_state       run_state;
        t_phase           phase;
        t_phase           next_phase;
        logic [CNT_W-1:0] focus_count;
        logic [MS_W-1:0]  duration_ms;
    } t_snap;

endpackage

// ===== rtl/core/focus_break_phase_timer_unit.sv =====
// Top level of the focus/break phase timer: command decode, state and ms snapshot
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_kind, i_now_us, i_restore_*
//  out     | output    | o_out_valid / i_out_stall | o_run_state_out .. o_duration_ms
//  cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while i_out_stall is low; each result passes the
// input register, then the state update, reciprocal multiply and correction stages before
// it reaches the output ports. The state update is one 64-bit subtract and compare.
// Synchronous active-low reset clears the valid bits, returns the timer state to idle
// focus and loads the reset lengths into the config registers.
// An output stall fills the four stages in turn; o_in_stall rises only when all are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module focus_break_phase_timer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [63:0] i_now_us,
    input  logic [1:0]  i_restore_run_state,
    input  logic [1:0]  i_restore_phase,
    input  logic [1:0]  i_restore_next_phase,
    input  logic [2:0]  i_restore_focus_count,
    input  logic [25:0] i_restore_remaining_ms,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_run_state_out,
    output logic [1:0]  o_phase_out,
    output logic [1:0]  o_next_phase_out,
    output logic [2:0]  o_focus_count_out,
    output logic [25:0] o_remaining_ms,
    output logic [25:0] o_duration_ms,
    // configuration port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers
    logic [fbpt_pkg::SEC_W-1:0] r_focus_s;
    logic [fbpt_pkg::SEC_W-1:0] r_short_s;
    logic [fbpt_pkg::SEC_W-1:0] r_long_s;

    // Timer state
    fbpt_pkg::t_run_state             r_state,   n_state;
    fbpt_pkg::t_phase                 r_phase,   n_phase;
    fbpt_pkg::t_phase                 r_pending, n_pending;
    logic [fbpt_pkg::CNT_W-1:0]       r_cnt,     n_cnt;
    logic [fbpt_pkg::US_W-1:0]        r_left,    n_left;
    logic [fbpt_pkg::STAMP_W-1:0]     r_start,   n_start;

    // Input register
    logic                             r_in_v;
    fbpt_pkg::t_kind                  r_in_kind;
    logic [fbpt_pkg::STAMP_W-1:0]     r_in_now;
    logic [1:0]                       r_in_rs_run;
    logic [1:0]                       r_in_rs_phase;
    logic [1:0]                       r_in_rs_next;
    logic [fbpt_pkg::CNT_W-1:0]       r_in_rs_cnt;
    logic [fbpt_pkg::MS_W-1:0]        r_in_rs_ms;

    // Pipeline stages after the state update
    logic                             r_s1_v;
    fbpt_pkg::t_snap                  r_s1_snap;
    logic [fbpt_pkg::DIV_Y_W-1:0]     r_s1_y;
    logic                             r_s2_v;
    fbpt_pkg::t_snap                  r_s2_snap;
    logic [fbpt_pkg::DIV_Y_W-1:0]     r_s2_y;
    logic [fbpt_pkg::Q0_W-1:0]        r_s2_q0;
    logic                             r_out_v;
    fbpt_pkg::t_snap                  r_out_snap;
    logic [fbpt_pkg::MS_W-1:0]        r_out_rem;

    // Stage enables
    logic en_out, en_s2, en_s1, en_in, step;

    // Combinational step signals
    logic [fbpt_pkg::STAMP_W-1:0]     elapsed;
    logic                             expired;
    logic [fbpt_pkg::US_W-1:0]        left_cur;
    fbpt_pkg::t_phase                 load_ph;
    logic [fbpt_pkg::US_W-1:0]        load_us;
    logic [fbpt_pkg::MS_W-1:0]        rs_ms;
    logic [fbpt_pkg::US_W-1:0]        rs_us;
    logic [fbpt_pkg::CNT_W-1:0]       cnt_inc;
    logic                             stamp_now;
    logic [fbpt_pkg::US_W-1:0]        snap_us;
    fbpt_pkg::t_snap                  snap;
    logic [fbpt_pkg::PROD_W-1:0]      prod;
    logic [fbpt_pkg::DIV_Y_W-1:0]     rem_raw;
    logic [fbpt_pkg::Q0_W-1:0]        q_fix;

    // Length of a phase in seconds from the config registers
    function automatic logic [fbpt_pkg::SEC_W-1:0] phase_sec(
        input fbpt_pkg::t_phase           ph,
        input logic [fbpt_pkg::SEC_W-1:0] f_s,
        input logic [fbpt_pkg::SEC_W-1:0] s_s,
        input logic [fbpt_pkg::SEC_W-1:0] l_s
    );
        logic [fbpt_pkg::SEC_W-1:0] sec;
        case (ph)
            fbpt_pkg::PH_SHORT: sec = s_s;
            fbpt_pkg::PH_LONG:  sec = l_s;
            default:            sec = f_s;
        endcase
        return sec;
    endfunction

    // Clamp a restored phase code to long break
    function automatic fbpt_pkg::t_phase clamp_phase(input logic [1:0] p);
        return (p == 2'd3) ? fbpt_pkg::PH_LONG : fbpt_pkg::t_phase'(p);
    endfunction

    // Advance each stage when its successor is empty or moving
    assign en_out     = !r_out_v || !i_out_stall;
    assign en_s2      = !r_s2_v  || en_out;
    assign en_s1      = !r_s1_v  || en_s2;
    assign en_in      = !r_in_v  || en_s1;
    assign step       = r_in_v && en_s1;
    assign o_in_stall = !en_in;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focus_s <= fbpt_pkg::RST_FOCUS_S;
            r_short_s <= fbpt_pkg::RST_SHORT_S;
            r_long_s  <= fbpt_pkg::RST_LONG_S;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fbpt_pkg::CFG_FOCUS: r_focus_s <= i_cfg_data;
                fbpt_pkg::CFG_SHORT: r_short_s <= i_cfg_data;
                fbpt_pkg::CFG_LONG:  r_long_s  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en_in) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_in_kind     <= fbpt_pkg::t_kind'(i_kind);
            r_in_now      <= i_now_us;
            r_in_rs_run   <= i_restore_run_state;
            r_in_rs_phase <= i_restore_phase;
            r_in_rs_next  <= i_restore_next_phase;
            r_in_rs_cnt   <= i_restore_focus_count;
            r_in_rs_ms    <= i_restore_remaining_ms;
        end
    end

    // Time left at the item's timestamp under the current state
    assign elapsed  = r_in_now - r_start;
    assign expired  = (elapsed >= {{(fbpt_pkg::STAMP_W - fbpt_pkg::US_W){1'b0}}, r_left});
    assign left_cur = (r_state != fbpt_pkg::ST_RUN) ? r_left :
                      (expired ? '0 : (r_left - elapsed[fbpt_pkg::US_W-1:0]));

    // Phase length to load, and the restored time
    assign load_ph = (r_in_kind == fbpt_pkg::KIND_ACK) ? r_pending : r_phase;
    assign load_us = fbpt_pkg::US_W'(phase_sec(load_ph, r_focus_s, r_short_s, r_long_s))
                     * fbpt_pkg::US_PER_S;
    assign rs_ms   = (r_in_rs_ms > fbpt_pkg::MAX_REMAIN_MS) ? fbpt_pkg::MAX_REMAIN_MS
                                                            : r_in_rs_ms;
    assign rs_us   = fbpt_pkg::US_W'(rs_ms) * fbpt_pkg::US_PER_MS;
    assign cnt_inc = (r_cnt < fbpt_pkg::FOCUS_PER_CYCLE) ? (r_cnt + 3'd1) : r_cnt;

    // Next state for the command
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_pending = r_pending;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_start   = r_start;
        stamp_now = 1'b0;
        case (r_in_kind)
            fbpt_pkg::KIND_TICK: begin
                if (r_state == fbpt_pkg::ST_RUN && left_cur == '0) begin
                    n_state = fbpt_pkg::ST_ALERT;
                    n_left  = '0;
                    if (r_phase == fbpt_pkg::PH_FOCUS) begin
                        n_cnt     = cnt_inc;
                        n_pending = (cnt_inc == fbpt_pkg::FOCUS_PER_CYCLE) ?
                                    fbpt_pkg::PH_LONG : fbpt_pkg::PH_SHORT;
                    end else begin
                        if (r_phase == fbpt_pkg::PH_LONG) begin
                            n_cnt = '0;
                        end
                        n_pending = fbpt_pkg::PH_FOCUS;
                    end
                end
            end
            fbpt_pkg::KIND_START: begin
                if (r_state == fbpt_pkg::ST_IDLE) begin
                    n_left    = load_us;
                    n_start   = r_in_now;
                    n_state   = fbpt_pkg::ST_RUN;
                    stamp_now = 1'b1;
                end
            end
            fbpt_pkg::KIND_PAUSE: begin
                if (r_state == fbpt_pkg::ST_RUN) begin
                    n_left  = left_cur;
                    n_state = fbpt_pkg::ST_PAUSE;
                end
            end
            fbpt_pkg::KIND_RESUME: begin
                if (r_state == fbpt_pkg::ST_PAUSE) begin
                    n_start   = r_in_now;
                    n_state   = fbpt_pkg::ST_RUN;
                    stamp_now = 1'b1;
                end
            end
            fbpt_pkg::KIND_STOP: begin
                n_state = fbpt_pkg::ST_IDLE;
                n_left  = load_us;
            end
            fbpt_pkg::KIND_ACK: begin
                if (r_state == fbpt_pkg::ST_ALERT) begin
                    n_phase = r_pending;
                    n_state = fbpt_pkg::ST_IDLE;
                    n_left  = load_us;
                end
            end
            fbpt_pkg::KIND_RESTORE: begin
                n_state   = fbpt_pkg::t_run_state'(r_in_rs_run);
                n_phase   = clamp_phase(r_in_rs_phase);
                n_pending = clamp_phase(r_in_rs_next);
                n_cnt     = (r_in_rs_cnt > fbpt_pkg::FOCUS_PER_CYCLE) ?
                            fbpt_pkg::FOCUS_PER_CYCLE : r_in_rs_cnt;
                n_left    = rs_us;
                n_start   = r_in_now;
                stamp_now = 1'b1;
            end
            default: ;
        endcase
    end

    // Snapshot after the command, at the item's timestamp
    always_comb begin
        snap_us          = (n_state == fbpt_pkg::ST_RUN && !stamp_now) ? left_cur : n_left;
        snap.run_state   = n_state;
        snap.phase       = n_phase;
        snap.next_phase  = n_pending;
        snap.focus_count = n_cnt;
        snap.duration_ms = fbpt_pkg::MS_W'(phase_sec(n_phase, r_focus_s, r_short_s, r_long_s))
                           * fbpt_pkg::MS_PER_S;
    end

    // Update the timer state on each stepped item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fbpt_pkg::ST_IDLE;
            r_phase   <= fbpt_pkg::PH_FOCUS;
            r_pending <= fbpt_pkg::PH_FOCUS;
            r_cnt     <= '0;
            r_left    <= fbpt_pkg::RST_LEFT_US;
            r_start   <= '0;
        end else if (step) begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_cnt     <= n_cnt;
            r_left    <= n_left;
            r_start   <= n_start;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (en_s1) begin
                r_s1_v <= r_in_v;
            end
            if (en_s2) begin
                r_s2_v <= r_s1_v;
            end
            if (en_out) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    // Stage 1: hold the snapshot, drop the low three bits for the divide by 1000
    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_snap <= snap;
            r_s1_y    <= snap_us[fbpt_pkg::US_W-1:3];
        end
    end

    // Stage 2: estimate the quotient by 125 with a reciprocal multiply
    assign prod = fbpt_pkg::PROD_W'(r_s1_y) * fbpt_pkg::PROD_W'(fbpt_pkg::DIV125_RECIP);

    always_ff @(posedge i_clk) begin
        if (en_s2) begin
            r_s2_snap <= r_s1_snap;
            r_s2_y    <= r_s1_y;
            r_s2_q0   <= prod[fbpt_pkg::PROD_W-1:fbpt_pkg::RECIP_SHIFT];
        end
    end

    // Stage 3: correct the estimate, which is low by at most one
    assign rem_raw = r_s2_y - (fbpt_pkg::DIV_Y_W'(r_s2_q0) * fbpt_pkg::DIVISOR_125);
    assign q_fix   = (rem_raw >= fbpt_pkg::DIVISOR_125) ? (r_s2_q0 + 1'b1) : r_s2_q0;

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_snap <= r_s2_snap;
            r_out_rem  <= q_fix[fbpt_pkg::MS_W-1:0];
        end
    end

    // Drive the result ports
    assign o_out_valid       = r_out_v;
    assign o_run_state_out   = r_out_snap.run_state;
    assign o_phase_out       = r_out_snap.phase;
    assign o_next_phase_out  = r_out_snap.next_phase;
    assign o_focus_count_out = r_out_snap.focus_count;
    assign o_remaining_ms    = r_out_rem;
    assign o_duration_ms     = r_out_snap.duration_ms;

    // Assertions
    `FBPT_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= fbpt_pkg::FOCUS_PER_CYCLE)
    `FBPT_ASSERT_IMPLY(a_div_one_fix, i_clk, i_rst_n, r_s2_v, rem_raw < (2 * fbpt_pkg::DIVISOR_125))
    `FBPT_ASSERT_IMPLY(a_stall_full, i_clk, i_rst_n, o_in_stall, r_in_v && r_s1_v && r_s2_v && r_out_v)

endmodule
